[src/srr_pkg.sv]
// Shared types, widths and helpers of the selective-repeat receiver.
package srr_pkg;

   localparam int SEQ_W            = 31;
   localparam int CSUM_W           = 32;
   localparam int PLO_W            = 64;
   localparam int PMID_W           = 64;
   localparam int PHI_W            = 32;
   localparam int PAYLOAD_BYTES    = 20;
   localparam int PAYLOAD_W        = PLO_W + PMID_W + PHI_W;
   localparam int GROUP_BYTES      = 5;
   localparam int GROUPS           = PAYLOAD_BYTES / GROUP_BYTES;
   localparam int GROUP_SUM_W      = 11;
   localparam int BYTES_SUM_W      = 13;
   localparam int REQ_TDATA_W      = 256;
   localparam int RSP_TDATA_W      = 224;
   localparam int WINDOW_SLOTS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF  = 2;

   localparam logic KIND_ACK  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SUM,
      F_TOTAL,
      F_CHECK
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_CALC,
      B_ACK,
      B_READ,
      B_DELIVER
   } back_state_type;

   // Request beat, last declared field (seq_number) in the lowest bits.
   typedef struct packed {
      logic [REQ_TDATA_W-SEQ_W-SEQ_W-CSUM_W-PAYLOAD_W-1:0] pad;
      logic [PHI_W-1:0]         payload_high;
      logic [PMID_W-1:0]        payload_mid;
      logic [PLO_W-1:0]         payload_low;
      logic signed [CSUM_W-1:0] packet_checksum;
      logic [SEQ_W-1:0]         ack_field;
      logic [SEQ_W-1:0]         seq_number;
   } req_data_type;

   // Result beat, last declared field (ack_number) in the lowest bits.
   typedef struct packed {
      logic [RSP_TDATA_W-SEQ_W-SEQ_W-PAYLOAD_W-1:0] pad;
      logic [PHI_W-1:0]  out_payload_high;
      logic [PMID_W-1:0] out_payload_mid;
      logic [PLO_W-1:0]  out_payload_low;
      logic [SEQ_W-1:0]  ack_checksum;
      logic [SEQ_W-1:0]  ack_number;
   } rsp_data_type;

   // Packet that passed the checksum, as it travels through the queue.
   typedef struct packed {
      logic [SEQ_W-1:0]  seq;
      logic [PHI_W-1:0]  phi;
      logic [PMID_W-1:0] pmid;
      logic [PLO_W-1:0]  plo;
   } packet_type;

   // Sum of five payload bytes, each taken as signed.
   function automatic logic signed [GROUP_SUM_W-1:0] group_sum(
      input logic [GROUP_BYTES*8-1:0] bytes
   );
      logic signed [GROUP_SUM_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < GROUP_BYTES; i++) begin
         acc = acc + {{(GROUP_SUM_W-8){bytes[8*i+7]}}, bytes[8*i +: 8]};
      end
      return acc;
   endfunction

endpackage

[src/srr_front.sv]
// Front end: take a packet beat, verify its checksum, pass good packets on.
module srr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  srr_pkg::req_data_type req_data,
   output logic                 push_valid,
   input  logic                 push_ready,
   output srr_pkg::packet_type  push_data
);

   srr_pkg::front_state_type state_ff, state_in;

   srr_pkg::packet_type                       packet_ff;
   logic [srr_pkg::CSUM_W-1:0]                checksum_ff;
   logic [srr_pkg::CSUM_W-1:0]                base_ff;
   logic [srr_pkg::CSUM_W-1:0]                total_ff;
   logic signed [srr_pkg::GROUP_SUM_W-1:0]    parts_ff [srr_pkg::GROUPS];
   logic signed [srr_pkg::BYTES_SUM_W-1:0]    bytes_total;
   logic [srr_pkg::PAYLOAD_W-1:0]             payload_flat;
   logic                                      good;

   assign payload_flat = {packet_ff.phi, packet_ff.pmid, packet_ff.plo};
   assign good         = (total_ff == checksum_ff);
   assign push_data    = packet_ff;

   always_comb begin
      bytes_total = '0;
      for (int g = 0; g < srr_pkg::GROUPS; g++) begin
         bytes_total = bytes_total + srr_pkg::BYTES_SUM_W'(parts_ff[g]);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srr_pkg::F_IDLE:  if (req_tvalid) state_in = srr_pkg::F_SUM;
         srr_pkg::F_SUM:   state_in = srr_pkg::F_TOTAL;
         srr_pkg::F_TOTAL: state_in = srr_pkg::F_CHECK;
         srr_pkg::F_CHECK: begin
            if (!good || push_ready) state_in = srr_pkg::F_IDLE;
         end
         default:          state_in = srr_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         srr_pkg::F_IDLE:  req_tready = 1'b1;
         srr_pkg::F_CHECK: push_valid = good;
         default: begin
            req_tready = 1'b0;
            push_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srr_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         packet_ff.seq  <= req_data.seq_number;
         packet_ff.plo  <= req_data.payload_low;
         packet_ff.pmid <= req_data.payload_mid;
         packet_ff.phi  <= req_data.payload_high;
         checksum_ff    <= req_data.packet_checksum;
         base_ff        <= {1'b0, req_data.seq_number} + {1'b0, req_data.ack_field};
      end
      if (state_ff == srr_pkg::F_SUM) begin
         for (int g = 0; g < srr_pkg::GROUPS; g++) begin
            parts_ff[g] <= srr_pkg::group_sum(
               payload_flat[g*srr_pkg::GROUP_BYTES*8 +: srr_pkg::GROUP_BYTES*8]);
         end
      end
      if (state_ff == srr_pkg::F_TOTAL) begin
         total_ff <= base_ff +
            {{(srr_pkg::CSUM_W-srr_pkg::BYTES_SUM_W){bytes_total[srr_pkg::BYTES_SUM_W-1]}},
             bytes_total};
      end
   end

endmodule

[src/srr_queue.sv]
// Small FIFO of checked packets between front end and window logic.
module srr_queue #(
   parameter int DEPTH = srr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  srr_pkg::packet_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output srr_pkg::packet_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   srr_pkg::packet_type entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue empty with pointers apart");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("queue count did not grow on push");

endmodule

[src/srr_back.sv]
// Back end: reorder window, payload store, ACK and in-order delivery beats.
module srr_back #(
   parameter int WINDOW_SLOTS = srr_pkg::WINDOW_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  srr_pkg::packet_type   pop_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output srr_pkg::rsp_data_type rsp_data,
   output logic                  rsp_kind,
   output logic                  rsp_last
);

   localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int SEQ_W  = srr_pkg::SEQ_W;

   srr_pkg::back_state_type state_ff, state_in;

   srr_pkg::packet_type            item_ff;
   logic [SEQ_W-1:0]               expected_ff;
   logic [SLOT_W-1:0]              head_ff;
   logic [WINDOW_SLOTS-1:0]        filled_ff;
   logic                           in_window_ff;
   logic [SLOT_W-1:0]              slot_ff;
   logic [srr_pkg::PAYLOAD_W-1:0]  slot_mem [WINDOW_SLOTS];
   logic [srr_pkg::PAYLOAD_W-1:0]  rd_data_ff;

   logic                           rsp_valid_ff;
   logic                           rsp_kind_ff;
   logic                           rsp_last_ff;
   srr_pkg::rsp_data_type          rsp_data_ff;
   srr_pkg::rsp_data_type          rsp_data_in;

   logic [SEQ_W:0]                 diff;
   logic [SLOT_W:0]                slot_sum;
   logic [SLOT_W-1:0]              slot_calc;
   logic                           in_window_calc;
   logic                           out_free;
   logic                           store_en;
   logic                           head_hit;
   logic [SLOT_W-1:0]              head_next;
   logic [WINDOW_SLOTS-1:0]        filled_clr;
   logic                           more;
   logic                           ack_fire;
   logic                           deliver_fire;
   logic                           rd_en;

   // Window position of the held packet relative to the expected number.
   assign diff           = {1'b0, item_ff.seq} - {1'b0, expected_ff};
   assign in_window_calc = !diff[SEQ_W] && (diff[SEQ_W-1:0] < SEQ_W'(WINDOW_SLOTS));
   assign slot_sum       = {1'b0, head_ff} + {1'b0, diff[SLOT_W-1:0]};
   assign slot_calc      = (slot_sum >= (SLOT_W+1)'(WINDOW_SLOTS))
                           ? SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW_SLOTS))
                           : slot_sum[SLOT_W-1:0];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign store_en   = in_window_ff && !filled_ff[slot_ff];
   assign head_hit   = filled_ff[head_ff] || (store_en && (slot_ff == head_ff));
   assign head_next  = ((&expected_ff) || (head_ff == SLOT_W'(WINDOW_SLOTS - 1)))
                       ? '0 : head_ff + 1'b1;
   assign filled_clr = filled_ff & ~(WINDOW_SLOTS'(1) << head_ff);
   assign more       = filled_clr[head_next];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srr_pkg::B_IDLE:    if (pop_valid) state_in = srr_pkg::B_CALC;
         srr_pkg::B_CALC:    state_in = srr_pkg::B_ACK;
         srr_pkg::B_ACK: begin
            if (out_free) state_in = head_hit ? srr_pkg::B_READ : srr_pkg::B_IDLE;
         end
         srr_pkg::B_READ:    state_in = srr_pkg::B_DELIVER;
         srr_pkg::B_DELIVER: begin
            if (out_free) state_in = more ? srr_pkg::B_READ : srr_pkg::B_IDLE;
         end
         default:            state_in = srr_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pop_ready    = 1'b0;
      ack_fire     = 1'b0;
      deliver_fire = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         srr_pkg::B_IDLE:    pop_ready    = 1'b1;
         srr_pkg::B_ACK:     ack_fire     = out_free;
         srr_pkg::B_READ:    rd_en        = 1'b1;
         srr_pkg::B_DELIVER: deliver_fire = out_free;
         default: begin
            pop_ready    = 1'b0;
            ack_fire     = 1'b0;
            deliver_fire = 1'b0;
            rd_en        = 1'b0;
         end
      endcase
   end

   // Build the next result beat; unused fields stay zero.
   always_comb begin
      rsp_data_in = '0;
      if (ack_fire) begin
         rsp_data_in.ack_number   = item_ff.seq;
         rsp_data_in.ack_checksum = item_ff.seq;
      end else begin
         rsp_data_in.out_payload_low  = rd_data_ff[srr_pkg::PLO_W-1:0];
         rsp_data_in.out_payload_mid  = rd_data_ff[srr_pkg::PLO_W +: srr_pkg::PMID_W];
         rsp_data_in.out_payload_high =
            rd_data_ff[srr_pkg::PLO_W+srr_pkg::PMID_W +: srr_pkg::PHI_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srr_pkg::B_IDLE;
         expected_ff  <= '0;
         head_ff      <= '0;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ack_fire && store_en) begin
            filled_ff[slot_ff] <= 1'b1;
         end
         if (deliver_fire) begin
            filled_ff   <= filled_clr;
            expected_ff <= expected_ff + 1'b1;
            head_ff     <= head_next;
         end
         if (ack_fire || deliver_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         item_ff <= pop_data;
      end
      if (state_ff == srr_pkg::B_CALC) begin
         in_window_ff <= in_window_calc;
         slot_ff      <= slot_calc;
      end
      if (ack_fire && store_en) begin
         slot_mem[slot_ff] <= {item_ff.phi, item_ff.pmid, item_ff.plo};
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[head_ff];
      end
      if (ack_fire) begin
         rsp_kind_ff <= srr_pkg::KIND_ACK;
         rsp_last_ff <= !head_hit;
      end else if (deliver_fire) begin
         rsp_kind_ff <= srr_pkg::KIND_DATA;
         rsp_last_ff <= !more;
      end
      if (ack_fire || deliver_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_data   = rsp_data_ff;

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= SLOT_W'(WINDOW_SLOTS - 1))
      else $error("head slot out of window");

   a_deliver_filled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srr_pkg::B_DELIVER) |-> filled_ff[head_ff])
      else $error("delivering from an empty head slot");

   a_expected_step: assert property (@(posedge clock) disable iff (reset)
      deliver_fire |=> (expected_ff == SEQ_W'($past(expected_ff) + 1'b1)))
      else $error("expected number did not advance on delivery");

endmodule

[src/selective_repeat_receiver_unit.sv]
// Selective-repeat ARQ receiver: checksum front end, queue, reorder window back end.
// Path: an accepted request beat passes front states F_SUM, F_TOTAL, F_CHECK, the queue,
// then back states B_CALC and B_ACK to the ACK beat; each stored payload then follows via
// B_READ (store read) and B_DELIVER (output register). The front end takes no new beat
// until the last one is checked (adder tree); the back end none until its beats are out.
// Reset clears both state machines, the queue, the expected number and the slot
// valid bits; the payload store is not cleared and needs no clearing pass.
module selective_repeat_receiver_unit #(
   parameter int WINDOW_SLOTS = srr_pkg::WINDOW_SLOTS_DEF,
   parameter int QUEUE_DEPTH  = srr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel: one packet per beat.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata, lowest bit up: seq_number[30:0], ack_field[30:0],
   // packet_checksum[31:0], payload_low[63:0], payload_mid[63:0],
   // payload_high[31:0], two zero bits
   input  logic [srr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Result channel: ACK and delivered payload beats.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata, lowest bit up: ack_number[30:0], ack_checksum[30:0],
   // out_payload_low[63:0], out_payload_mid[63:0], out_payload_high[31:0],
   // two zero bits
   output logic [srr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: result_kind (0 ACK, 1 payload delivered)
   output logic [0:0]                      rsp_tuser,
   // rsp_tlast: final beat caused by one packet
   output logic                            rsp_tlast
);

   srr_pkg::req_data_type req_data;
   srr_pkg::rsp_data_type rsp_data;
   srr_pkg::packet_type   push_data, pop_data;
   logic                  push_valid, push_ready;
   logic                  pop_valid, pop_ready;
   logic                  rsp_kind;

   assign req_data = req_tdata;

   // Verify the checksum; drop bad packets without a result.
   srr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Hold good packets while the back end drains deliveries.
   srr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Acknowledge, store into the window, deliver in order.
   srr_back #(
      .WINDOW_SLOTS (WINDOW_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data),
      .rsp_kind   (rsp_kind),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = rsp_data;
   assign rsp_tuser = rsp_kind;

endmodule

[dv/tb_selective_repeat_receiver_unit.sv]
// Self-checking testbench for the selective-repeat receiver: ACK and in-order delivery.
module tb_selective_repeat_receiver_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // One expected result beat, as the result channel should show it.
   typedef struct packed {
      logic                       kind;
      logic [srr_pkg::SEQ_W-1:0]  ack_number;
      logic [srr_pkg::SEQ_W-1:0]  ack_checksum;
      logic [srr_pkg::PLO_W-1:0]  plo;
      logic [srr_pkg::PMID_W-1:0] pmid;
      logic [srr_pkg::PHI_W-1:0]  phi;
      logic                       last;
   } rsp_beat_type;

   // Payload shapes used to hit the byte extremes of the checksum.
   typedef enum int {
      PAT_RANDOM,
      PAT_ZERO,
      PAT_ONES,
      PAT_MOST_NEG,
      PAT_MOST_POS
   } payload_pattern_type;

   // Tracks the reorder window and keeps the beats each accepted packet must produce.
   class srr_scoreboard;
      localparam int SLOTS = srr_pkg::WINDOW_SLOTS_DEF;

      logic [srr_pkg::SEQ_W-1:0]  next_seq;
      bit                         slot_full [SLOTS];
      logic [srr_pkg::PLO_W-1:0]  slot_lo   [SLOTS];
      logic [srr_pkg::PMID_W-1:0] slot_mid  [SLOTS];
      logic [srr_pkg::PHI_W-1:0]  slot_hi   [SLOTS];
      rsp_beat_type               beats_due [$];

      int errors;
      int packets_taken;
      int corrupt_packets;
      int ack_only_packets;
      int ack_beats;
      int data_beats;
      int longest_burst;

      function new();
         next_seq = '0;
         foreach (slot_full[i]) slot_full[i] = 1'b0;
      endfunction

      // 32-bit wrapping sum of seq, ack field and the payload bytes taken as signed.
      static function logic [31:0] packet_sum(srr_pkg::req_data_type p);
         logic [31:0]                   acc;
         logic [srr_pkg::PAYLOAD_W-1:0] bytes;
         acc   = 32'(p.seq_number) + 32'(p.ack_field);
         bytes = {p.payload_high, p.payload_mid, p.payload_low};
         for (int i = 0; i < srr_pkg::PAYLOAD_BYTES; i++) begin
            acc = acc + {{24{bytes[8*i+7]}}, bytes[8*i +: 8]};
         end
         return acc;
      endfunction

      function int outstanding();
         return beats_due.size();
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      // Advance the window for one accepted packet and queue the beats it causes.
      function void take_packet(srr_pkg::req_data_type p);
         rsp_beat_type              burst [$];
         rsp_beat_type              b;
         logic [srr_pkg::SEQ_W-1:0] seq;
         int                        idx;
         packets_taken++;
         if (packet_sum(p) != p.packet_checksum) begin
            corrupt_packets++;
            return;
         end
         seq = p.seq_number;
         b = '0;
         b.kind         = srr_pkg::KIND_ACK;
         b.ack_number   = seq;
         b.ack_checksum = seq;
         burst.push_back(b);
         idx = int'(seq % SLOTS);
         if (seq >= next_seq && (seq - next_seq) < SLOTS && !slot_full[idx]) begin
            slot_full[idx] = 1'b1;
            slot_lo[idx]   = p.payload_low;
            slot_mid[idx]  = p.payload_mid;
            slot_hi[idx]   = p.payload_high;
         end else begin
            ack_only_packets++;
         end
         while (slot_full[int'(next_seq % SLOTS)]) begin
            idx = int'(next_seq % SLOTS);
            b = '0;
            b.kind = srr_pkg::KIND_DATA;
            b.plo  = slot_lo[idx];
            b.pmid = slot_mid[idx];
            b.phi  = slot_hi[idx];
            burst.push_back(b);
            slot_full[idx] = 1'b0;
            next_seq = next_seq + 1'b1;
         end
         for (int i = 0; i < burst.size(); i++) begin
            b = burst[i];
            b.last = (i == burst.size() - 1);
            beats_due.push_back(b);
         end
         if (burst.size() > longest_burst) longest_burst = burst.size();
      endfunction

      // Compare one accepted result beat with the oldest expected one.
      task check_beat(logic kind, srr_pkg::rsp_data_type d, logic last);
         rsp_beat_type want;
         if (beats_due.size() == 0) begin
            report($sformatf("unexpected result beat kind=%0b", kind));
            return;
         end
         want = beats_due.pop_front();
         if (want.kind == srr_pkg::KIND_ACK) ack_beats++;
         else data_beats++;
         if (kind !== want.kind)
            report($sformatf("kind got %0b want %0b", kind, want.kind));
         if (d.ack_number !== want.ack_number)
            report($sformatf("ack_number got %h want %h", d.ack_number, want.ack_number));
         if (d.ack_checksum !== want.ack_checksum)
            report($sformatf("ack_checksum got %h want %h", d.ack_checksum,
                             want.ack_checksum));
         if (d.out_payload_low !== want.plo)
            report($sformatf("payload_low got %h want %h", d.out_payload_low, want.plo));
         if (d.out_payload_mid !== want.pmid)
            report($sformatf("payload_mid got %h want %h", d.out_payload_mid, want.pmid));
         if (d.out_payload_high !== want.phi)
            report($sformatf("payload_high got %h want %h", d.out_payload_high, want.phi));
         if (d.pad !== '0)
            report($sformatf("tdata fill bits got %b", d.pad));
         if (last !== want.last)
            report($sformatf("tlast got %0b want %0b", last, want.last));
      endtask
   endclass

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [srr_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [srr_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]                      rsp_tuser;
   logic                            rsp_tlast;

   srr_scoreboard sb = new();

   // Set by the stimulus to make both sides run without idle cycles.
   bit steady = 1'b0;
   // Handed to the result sink to ask for one long back-pressure stretch.
   int sink_holdoff_cycles = 0;

   always #5 clock = ~clock;

   selective_repeat_receiver_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Build a packet for one sequence number; corrupt flips checksum bits.
   function automatic srr_pkg::req_data_type make_packet(
      logic [srr_pkg::SEQ_W-1:0] seq, payload_pattern_type pat, bit corrupt);
      srr_pkg::req_data_type p;
      logic [31:0]           flip;
      p = '0;
      p.seq_number = seq;
      case (pat)
         PAT_ZERO: begin
            p.ack_field = '0;
         end
         PAT_ONES: begin
            p.ack_field    = '1;
            p.payload_low  = '1;
            p.payload_mid  = '1;
            p.payload_high = '1;
         end
         PAT_MOST_NEG: begin
            p.ack_field    = srr_pkg::SEQ_W'($urandom);
            p.payload_low  = {8{8'h80}};
            p.payload_mid  = {8{8'h80}};
            p.payload_high = {4{8'h80}};
         end
         PAT_MOST_POS: begin
            p.ack_field    = srr_pkg::SEQ_W'($urandom);
            p.payload_low  = {8{8'h7F}};
            p.payload_mid  = {8{8'h7F}};
            p.payload_high = {4{8'h7F}};
         end
         default: begin
            p.ack_field    = srr_pkg::SEQ_W'($urandom);
            p.payload_low  = {$urandom, $urandom};
            p.payload_mid  = {$urandom, $urandom};
            p.payload_high = $urandom;
         end
      endcase
      p.packet_checksum = srr_scoreboard::packet_sum(p);
      if (corrupt) begin
         flip = $urandom;
         if (flip == 0) flip = 32'h1;
         p.packet_checksum = p.packet_checksum ^ flip;
      end
      return p;
   endfunction

   function automatic payload_pattern_type pick_pattern();
      if ($urandom_range(0, 99) < 6)
         return payload_pattern_type'($urandom_range(PAT_ZERO, PAT_MOST_POS));
      return PAT_RANDOM;
   endfunction

   // Offer one packet and hold it until the block takes it; then maybe idle a while.
   task automatic send_packet(srr_pkg::req_data_type p);
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      sb.take_packet(p);
      if (!steady && $urandom_range(0, 99) < 18) begin
         // Drop valid and park junk on the bus during the gap.
         req_tvalid <= 1'b0;
         req_tdata  <= {8{$urandom}};
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every queued result beat has come out.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Choose a packet relative to the current head of the window.
   task automatic pick_packet(output srr_pkg::req_data_type p, output bit corrupt);
      logic [srr_pkg::SEQ_W-1:0] head;
      logic [srr_pkg::SEQ_W-1:0] seq;
      int                        roll;
      head    = sb.next_seq;
      roll    = $urandom_range(0, 99);
      corrupt = 1'b0;
      if (roll < 8) begin
         // Corrupt checksum, anywhere in the number space or inside the window.
         corrupt = 1'b1;
         seq = ($urandom_range(0, 1) != 0) ? srr_pkg::SEQ_W'($urandom)
                                           : srr_pkg::SEQ_W'(head + $urandom_range(0, 15));
      end else if (roll < 68) begin
         seq = srr_pkg::SEQ_W'(head + $urandom_range(0, 15));
      end else if (roll < 80) begin
         seq = head;
      end else if (roll < 88) begin
         // Late duplicate below the head.
         if (head > 0)
            seq = srr_pkg::SEQ_W'(head - $urandom_range(1, (head > 20) ? 20 : int'(head)));
         else
            seq = srr_pkg::SEQ_W'(head + $urandom_range(0, 15));
      end else if (roll < 95) begin
         seq = srr_pkg::SEQ_W'(head + 16 + $urandom_range(0, 40));
      end else begin
         seq = srr_pkg::SEQ_W'($urandom);
      end
      p = make_packet(seq, pick_pattern(), corrupt);
   endtask

   task automatic run_directed();
      logic [srr_pkg::SEQ_W-1:0] head;
      srr_pkg::req_data_type     p;
      // In-order head with an all-zero packet, then corrupt retries of the next one.
      send_packet(make_packet('0, PAT_ZERO, 1'b0));
      p = make_packet(srr_pkg::SEQ_W'(1), PAT_RANDOM, 1'b0);
      p.packet_checksum = 32'h8000_0000;
      send_packet(p);
      p = make_packet(srr_pkg::SEQ_W'(1), PAT_RANDOM, 1'b0);
      p.packet_checksum = 32'h7FFF_FFFF;
      send_packet(p);
      // Byte extremes through the checksum and the payload path.
      send_packet(make_packet(srr_pkg::SEQ_W'(1), PAT_ONES, 1'b0));
      send_packet(make_packet(srr_pkg::SEQ_W'(2), PAT_MOST_NEG, 1'b0));
      send_packet(make_packet(srr_pkg::SEQ_W'(3), PAT_MOST_POS, 1'b0));
      // Duplicate, first number past the window, and the top sequence number.
      send_packet(make_packet('0, PAT_RANDOM, 1'b0));
      send_packet(make_packet(srr_pkg::SEQ_W'(sb.next_seq + 16), PAT_RANDOM, 1'b0));
      send_packet(make_packet('1, PAT_RANDOM, 1'b0));
      // Occupied slot: the second copy must not replace the stored payload.
      head = sb.next_seq;
      send_packet(make_packet(srr_pkg::SEQ_W'(head + 1), PAT_RANDOM, 1'b0));
      send_packet(make_packet(srr_pkg::SEQ_W'(head + 1), PAT_RANDOM, 1'b0));
      send_packet(make_packet(head, PAT_RANDOM, 1'b0));
      // Fill the whole window backwards, then release it with the head: longest burst.
      head = sb.next_seq;
      for (int k = srr_pkg::WINDOW_SLOTS_DEF - 1; k >= 1; k--) begin
         send_packet(make_packet(srr_pkg::SEQ_W'(head + k), PAT_RANDOM, 1'b0));
      end
      send_packet(make_packet(head, PAT_RANDOM, 1'b0));
   endtask

   task automatic run_random(int count);
      srr_pkg::req_data_type     p;
      bit                        corrupt;
      int                        good;
      int                        n;
      int                        j;
      int                        tmp;
      int                        order [srr_pkg::WINDOW_SLOTS_DEF];
      logic [srr_pkg::SEQ_W-1:0] head;
      good = 0;
      while (good < count) begin
         // Hold a stretch in the middle with no idling on either side.
         steady = (good >= 150 && good < 250);
         if ($urandom_range(0, 99) < 10) begin
            // Shuffled run of consecutive numbers starting at the head.
            n    = $urandom_range(2, srr_pkg::WINDOW_SLOTS_DEF);
            head = sb.next_seq;
            for (int i = 0; i < n; i++) order[i] = i;
            for (int i = n - 1; i > 0; i--) begin
               j        = $urandom_range(0, i);
               tmp      = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            for (int i = 0; i < n; i++) begin
               send_packet(make_packet(srr_pkg::SEQ_W'(head + order[i]), pick_pattern(),
                                       1'b0));
            end
            good += n;
         end else begin
            pick_packet(p, corrupt);
            send_packet(p);
            if (!corrupt) good++;
         end
      end
      steady = 1'b0;
   endtask

   // Result sink: check every accepted beat, then pick tready for the next cycle.
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_beat(rsp_tuser[0], srr_pkg::rsp_data_type'(rsp_tdata), rsp_tlast);
         if (sink_holdoff_cycles != 0) begin
            hold_left           = sink_holdoff_cycles;
            sink_holdoff_cycles = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 18);
         end
      end
   end

   initial begin : stimulus
      srr_pkg::req_data_type p;
      bit                    corrupt;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      drain_results();

      // Back-pressure: stall the sink long enough that the block fills and stalls input.
      sink_holdoff_cycles = 400;
      repeat (40) begin
         pick_packet(p, corrupt);
         send_packet(p);
      end
      drain_results();

      run_random(300);
      drain_results();
      // Allow for stray beats after the last expected one.
      repeat (60) @(posedge clock);

      $display("Covered %0d packets: %0d with a corrupt checksum, %0d ACK-only",
               sb.packets_taken, sb.corrupt_packets, sb.ack_only_packets);
      $display("Checked %0d ACK beats and %0d payload beats, longest burst %0d beats",
               sb.ack_beats, sb.data_beats, sb.longest_burst);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: end a hung run.
   initial begin : watchdog
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

[sim.f]
src/srr_pkg.sv
src/srr_front.sv
src/srr_queue.sv
src/srr_back.sv
src/selective_repeat_receiver_unit.sv
dv/tb_selective_repeat_receiver_unit.sv
